>>> hw/rtl/sbrc_pkg.sv
// ----------------------------------------------------------------------------
// sbrc_pkg
// Shared constants, stage map, word types and divider helpers for the
// scaled blit rectangle clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrc_pkg;

    localparam int FRACTION_BITS = 16;

    // magnitude of a shifted numerator, quotient bits kept, leading dividend bits
    localparam int NW = 32 + FRACTION_BITS;
    localparam int QW = 33;
    localparam int HW = NW - QW;

    // pipeline stage map
    localparam int ST_CORNER = 0;
    localparam int ST_DIFF   = 1;
    localparam int ST_ABS    = 2;
    localparam int ST_INIT   = 3;
    localparam int ST_DIV0   = 4;
    localparam int ST_SCALE  = ST_DIV0 + QW;
    localparam int ST_MUL    = ST_SCALE + 1;
    localparam int ST_OUT    = ST_MUL + 1;
    localparam int N_STG     = ST_OUT + 1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [QW-1:0] Q_POS_LIM = QW'(33'h0_7FFF_FFFF);
    localparam logic [QW-1:0] Q_NEG_LIM = QW'(33'h1_0000_0000);

    typedef enum logic [1:0] {
        CFG_CLIP_LEFT,
        CFG_CLIP_TOP,
        CFG_CLIP_RIGHT,
        CFG_CLIP_BOTTOM
    } t_cfg_idx;

    typedef struct packed {
        logic signed [32:0] den;
        logic               neg;
        logic               zero;
        logic [NW-1:0]      n;
        logic [31:0]        d;
        logic [31:0]        r;
        logic [QW-1:0]      q;
        logic               sat;
        logic signed [31:0] scl;
    } t_div;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] u0;
        logic signed [31:0] v0;
        logic signed [31:0] u1;
        logic signed [31:0] v1;
        logic signed [31:0] x0c;
        logic signed [31:0] y0c;
        logic signed [32:0] dlx;
        logic signed [32:0] dly;
        logic signed [32:0] drx;
        logic signed [32:0] dry;
        logic signed [31:0] plu;
        logic signed [31:0] pru;
        logic signed [31:0] plv;
        logic signed [31:0] prv;
        logic               rej;
        logic [3:0]         flg;
        t_div               du;
        t_div               dv;
    } t_item;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div div_step(input t_div a, input logic nb);
        t_div        b;
        logic [32:0] t;
        b = a;
        t = {a.r, nb};
        if (t >= {1'b0, a.d}) begin
            b.r = 32'(t - {1'b0, a.d});
            b.q = {a.q[QW-2:0], 1'b1};
        end else begin
            b.r = t[31:0];
            b.q = {a.q[QW-2:0], 1'b0};
        end
        return b;
    endfunction

    // sign and saturation of the quotient magnitude
    function automatic logic signed [31:0] div_scale(input t_div a, input logic num_neg);
        logic signed [31:0] s;
        if (a.zero) begin
            s = num_neg ? S32_MIN : S32_MAX;
        end else if (!a.neg) begin
            s = (a.sat || (a.q > Q_POS_LIM)) ? S32_MAX : a.q[31:0];
        end else begin
            s = (a.sat || (a.q > Q_NEG_LIM)) ? S32_MIN : 32'(-a.q[31:0]);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scaled_blit_rect_clip_core.sv
// ----------------------------------------------------------------------------
// scaled_blit_rect_clip_core
// Clips a scaled blit rectangle against the clip window and returns the
// clipped 16.16 corners with their texture coordinates.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  request   in         i_in_valid / o_in_stall    i_pos_x .. i_tex_height
//  result    out        o_out_valid / i_out_stall  o_all_clipped .. o_out_v1
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  one word per cycle while no result is held, through a 40 stage pipeline
//  of which 33 stages are the bit-per-stage u and v scale dividers
//  synchronous active-low reset clears the stage valid bits and clip registers
//  a stalled result holds, stages behind it keep filling until no bubble is left
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_blit_rect_clip_core
    import sbrc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,

    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic signed [15:0] i_span_w,
    input  wire logic signed [15:0] i_span_h,
    input  wire logic [14:0]        i_tex_width,
    input  wire logic [14:0]        i_tex_height,

    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      logic               o_all_clipped,
    output      logic [3:0]         o_edge_flags,
    output      logic signed [31:0] o_out_x0,
    output      logic signed [31:0] o_out_y0,
    output      logic signed [31:0] o_out_x1,
    output      logic signed [31:0] o_out_y1,
    output      logic signed [31:0] o_out_u0,
    output      logic signed [31:0] o_out_v0,
    output      logic signed [31:0] o_out_u1,
    output      logic signed [31:0] o_out_v1
);

    logic signed [31:0] r_clip_left;
    logic signed [31:0] r_clip_top;
    logic signed [31:0] r_clip_right;
    logic signed [31:0] r_clip_bottom;

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_vld;
    logic [N_STG-1:0] rdy;
    t_item            r_stg [N_STG];
    t_item            n_stg [N_STG];

    always_comb begin
        rdy[N_STG-1] = !r_vld[N_STG-1] || !i_out_stall;
        for (int k = N_STG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign n_vld      = {r_vld[N_STG-2:0], i_in_valid};
    assign o_in_stall = !rdy[0];

    always_comb begin : p_next
        t_item              a;
        t_item              b;
        logic signed [16:0] s17;
        logic [31:0]        mag;
        logic [HW-1:0]      hd;
        logic signed [64:0] p;

        // corners
        b     = r_stg[ST_CORNER];
        b.x0  = 32'(i_pos_x) << FRACTION_BITS;
        b.y0  = 32'(i_pos_y) << FRACTION_BITS;
        s17   = 17'(i_pos_x) + 17'(i_span_w);
        b.x1  = 32'(s17) << FRACTION_BITS;
        s17   = 17'(i_pos_y) + 17'(i_span_h);
        b.y1  = 32'(s17) << FRACTION_BITS;
        b.u1  = 32'(i_tex_width) << FRACTION_BITS;
        b.v1  = 32'(i_tex_height) << FRACTION_BITS;
        n_stg[ST_CORNER] = b;

        // reject test, edge tests, spans and left/top distances
        a = r_stg[ST_CORNER];
        b = a;
        b.rej = (a.x0 >= r_clip_right) || (a.x1 <= r_clip_left) ||
                (a.y0 >= r_clip_bottom) || (a.y1 <= r_clip_top);
        b.flg = {a.y1 > r_clip_bottom, a.y0 < r_clip_top,
                 a.x1 > r_clip_right, a.x0 < r_clip_left};
        b.du.den = 33'(a.x1) - 33'(a.x0);
        b.dv.den = 33'(a.y1) - 33'(a.y0);
        b.dlx = 33'(r_clip_left) - 33'(a.x0);
        b.dly = 33'(r_clip_top) - 33'(a.y0);
        b.x0c = (a.x0 < r_clip_left) ? r_clip_left : a.x0;
        b.y0c = (a.y0 < r_clip_top) ? r_clip_top : a.y0;
        n_stg[ST_DIFF] = b;

        // magnitudes and right/bottom distances
        a = r_stg[ST_DIFF];
        b = a;
        b.du.zero = (a.du.den == '0);
        b.du.neg  = a.du.den[32] ^ a.u1[31];
        b.du.d    = a.du.den[32] ? 32'(-a.du.den) : a.du.den[31:0];
        mag       = a.u1[31] ? 32'(-a.u1) : a.u1;
        b.du.n    = NW'(mag) << FRACTION_BITS;
        b.dv.zero = (a.dv.den == '0);
        b.dv.neg  = a.dv.den[32] ^ a.v1[31];
        b.dv.d    = a.dv.den[32] ? 32'(-a.dv.den) : a.dv.den[31:0];
        mag       = a.v1[31] ? 32'(-a.v1) : a.v1;
        b.dv.n    = NW'(mag) << FRACTION_BITS;
        b.drx = 33'(r_clip_right) - 33'(a.x0c);
        b.dry = 33'(r_clip_bottom) - 33'(a.y0c);
        n_stg[ST_ABS] = b;

        // overflow check on the leading dividend bits, divider seed
        a = r_stg[ST_ABS];
        b = a;
        hd       = a.du.n[NW-1:QW];
        b.du.sat = (32'(hd) >= a.du.d);
        b.du.r   = 32'(hd);
        b.du.q   = '0;
        hd       = a.dv.n[NW-1:QW];
        b.dv.sat = (32'(hd) >= a.dv.d);
        b.dv.r   = 32'(hd);
        b.dv.q   = '0;
        n_stg[ST_INIT] = b;

        for (int k = 0; k < QW; k++) begin
            a = r_stg[ST_DIV0+k-1];
            b = a;
            b.du = div_step(a.du, a.du.n[QW-1-k]);
            b.dv = div_step(a.dv, a.dv.n[QW-1-k]);
            n_stg[ST_DIV0+k] = b;
        end

        a = r_stg[ST_SCALE-1];
        b = a;
        b.du.scl = div_scale(a.du, a.u1[31]);
        b.dv.scl = div_scale(a.dv, a.v1[31]);
        n_stg[ST_SCALE] = b;

        // scale times distance, floor shift
        a = r_stg[ST_SCALE];
        b = a;
        p     = a.du.scl * a.dlx;
        b.plu = p[FRACTION_BITS+31:FRACTION_BITS];
        p     = a.du.scl * a.drx;
        b.pru = p[FRACTION_BITS+31:FRACTION_BITS];
        p     = a.dv.scl * a.dly;
        b.plv = p[FRACTION_BITS+31:FRACTION_BITS];
        p     = a.dv.scl * a.dry;
        b.prv = p[FRACTION_BITS+31:FRACTION_BITS];
        n_stg[ST_MUL] = b;

        a = r_stg[ST_MUL];
        b = a;
        if (a.rej) begin
            b.flg = '0;
            b.u0  = '0;
            b.v0  = '0;
        end else begin
            b.u0 = a.flg[0] ? a.plu : '0;
            b.x0 = a.x0c;
            b.x1 = a.flg[1] ? r_clip_right : a.x1;
            b.u1 = a.flg[1] ? (b.u0 + a.pru) : a.u1;
            b.v0 = a.flg[2] ? a.plv : '0;
            b.y0 = a.y0c;
            b.y1 = a.flg[3] ? r_clip_bottom : a.y1;
            b.v1 = a.flg[3] ? (b.v0 + a.prv) : a.v1;
        end
        n_stg[ST_OUT] = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= '0;
            r_clip_bottom <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_data;
                    CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data;
                    CFG_CLIP_RIGHT:  r_clip_right  <= i_cfg_data;
                    CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data;
                    default: ;
                endcase
            end
            for (int k = 0; k < N_STG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_STG; k++) begin
            if (rdy[k] && n_vld[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_out_valid   = r_vld[ST_OUT];
    assign o_all_clipped = r_stg[ST_OUT].rej;
    assign o_edge_flags  = r_stg[ST_OUT].flg;
    assign o_out_x0      = r_stg[ST_OUT].x0;
    assign o_out_y0      = r_stg[ST_OUT].y0;
    assign o_out_x1      = r_stg[ST_OUT].x1;
    assign o_out_y1      = r_stg[ST_OUT].y1;
    assign o_out_u0      = r_stg[ST_OUT].u0;
    assign o_out_v0      = r_stg[ST_OUT].v0;
    assign o_out_u1      = r_stg[ST_OUT].u1;
    assign o_out_v1      = r_stg[ST_OUT].v1;

endmodule

`default_nettype wire

>>> hw/rtl/sbrc_checker.sv
// ----------------------------------------------------------------------------
// sbrc_checker
// Port-level checks for the scaled blit rectangle clipper.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_checker
    import sbrc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_all_clipped,
    input wire logic [3:0]         o_edge_flags,
    input wire logic signed [31:0] o_out_x0,
    input wire logic signed [31:0] o_out_u0,
    input wire logic signed [31:0] o_out_v0,
    input wire logic signed [31:0] o_out_u1
);

    localparam logic signed [31:0] ZERO32 = '0;

    // request side only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without a held result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_x0) && $stable(o_out_u1) &&
             $stable(o_edge_flags) && $stable(o_all_clipped)))
        else $error("stalled result word changed");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_all_clipped) |->
            (o_edge_flags == 4'b0000 && o_out_u0 == ZERO32 && o_out_v0 == ZERO32))
        else $error("rejected word carries clip results");

    a_unclipped_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_edge_flags[0] || o_out_u0 == ZERO32) &&
             (o_edge_flags[2] || o_out_v0 == ZERO32)))
        else $error("texture origin moved without an edge clip");

endmodule

bind scaled_blit_rect_clip_core sbrc_checker u_sbrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_all_clipped (o_all_clipped),
    .o_edge_flags  (o_edge_flags),
    .o_out_x0      (o_out_x0),
    .o_out_u0      (o_out_u0),
    .o_out_v0      (o_out_v0),
    .o_out_u1      (o_out_u1)
);

`default_nettype wire

>>> sim/scaled_blit_rect_clip_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaled_blit_rect_clip_core_tb
// Drives scaled blit requests through the clipper under a series of clip
// windows (reset, fixed, full range, random, fractional and inverted). Each
// accepted request is run through a local 16.16 clip calculation and the
// result word is checked field by field. Both sides idle in random bursts,
// and one long result hold-off backs the pipeline up into the request side.
// ----------------------------------------------------------------------------

module scaled_blit_rect_clip_core_tb;

    import sbrc_pkg::*;

    localparam int FB          = FRACTION_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] sw;
        logic signed [15:0] sh;
        logic [14:0]        tw;
        logic [14:0]        th;
    } t_blit_req;

    typedef struct packed {
        logic               rej;
        logic [3:0]         flg;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] u0;
        logic signed [31:0] v0;
        logic signed [31:0] u1;
        logic signed [31:0] v1;
    } t_clip_res;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [1:0]         i_cfg_idx    = '0;
    logic [31:0]        i_cfg_data   = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_pos_x      = '0;
    logic signed [15:0] i_pos_y      = '0;
    logic signed [15:0] i_span_w     = '0;
    logic signed [15:0] i_span_h     = '0;
    logic [14:0]        i_tex_width  = '0;
    logic [14:0]        i_tex_height = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic               o_all_clipped;
    logic [3:0]         o_edge_flags;
    logic signed [31:0] o_out_x0;
    logic signed [31:0] o_out_y0;
    logic signed [31:0] o_out_x1;
    logic signed [31:0] o_out_y1;
    logic signed [31:0] o_out_u0;
    logic signed [31:0] o_out_v0;
    logic signed [31:0] o_out_u1;
    logic signed [31:0] o_out_v1;

    // clip window as the block should hold it
    logic signed [31:0] win_left   = '0;
    logic signed [31:0] win_top    = '0;
    logic signed [31:0] win_right  = '0;
    logic signed [31:0] win_bottom = '0;

    t_blit_req  req_q[$];
    t_clip_res  clip_q[$];
    t_blit_req  cur_req    = '0;
    t_clip_res  mon_got;
    t_clip_res  mon_want;
    bit         req_fire   = 1'b0;
    int         idle_pct   = 0;
    int         req_gap    = 0;
    int         res_gap    = 0;
    int         hold_left  = 0;
    bit         hold_go    = 1'b0;
    bit         hold_done  = 1'b0;
    int         cycles     = 0;
    int         errors     = 0;
    int         n_words    = 0;

    scaled_blit_rect_clip_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_span_w      (i_span_w),
        .i_span_h      (i_span_h),
        .i_tex_width   (i_tex_width),
        .i_tex_height  (i_tex_height),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_all_clipped (o_all_clipped),
        .o_edge_flags  (o_edge_flags),
        .o_out_x0      (o_out_x0),
        .o_out_y0      (o_out_y0),
        .o_out_x1      (o_out_x1),
        .o_out_y1      (o_out_y1),
        .o_out_u0      (o_out_u0),
        .o_out_v0      (o_out_v0),
        .o_out_u1      (o_out_u1),
        .o_out_v1      (o_out_v1)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // 16.16 clip calculation
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] to_fix(longint whole);
        longint t;
        t = whole <<< FB;
        return t[31:0];
    endfunction

    function automatic logic signed [31:0] scale_div(logic signed [31:0] num, longint den);
        longint n;
        longint q;
        n = longint'(num) <<< FB;
        if (den == 0)
            return (num >= 0) ? S32_MAX : S32_MIN;
        q = n / den;
        if (q > longint'(S32_MAX))
            return S32_MAX;
        if (q < longint'(S32_MIN))
            return S32_MIN;
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] scale_mul(logic signed [31:0] a, longint b);
        longint p;
        p = (longint'(a) * b) >>> FB;
        return p[31:0];
    endfunction

    function automatic t_clip_res clip_predict(t_blit_req r);
        t_clip_res          o;
        logic signed [31:0] us;
        logic signed [31:0] vs;
        longint             t;
        o     = '0;
        o.x0  = to_fix(longint'(r.px));
        o.y0  = to_fix(longint'(r.py));
        o.x1  = to_fix(longint'(r.px) + longint'(r.sw));
        o.y1  = to_fix(longint'(r.py) + longint'(r.sh));
        o.u1  = to_fix(longint'(r.tw));
        o.v1  = to_fix(longint'(r.th));
        if (o.x0 >= win_right || o.x1 <= win_left || o.y0 >= win_bottom || o.y1 <= win_top) begin
            o.rej = 1'b1;
        end else begin
            us = scale_div(o.u1, longint'(o.x1) - longint'(o.x0));
            vs = scale_div(o.v1, longint'(o.y1) - longint'(o.y0));
            if (o.x0 < win_left) begin
                o.u0     = scale_mul(us, longint'(win_left) - longint'(o.x0));
                o.x0     = win_left;
                o.flg[0] = 1'b1;
            end
            if (o.x1 > win_right) begin
                o.x1     = win_right;
                t        = longint'(o.u0)
                         + longint'(scale_mul(us, longint'(o.x1) - longint'(o.x0)));
                o.u1     = t[31:0];
                o.flg[1] = 1'b1;
            end
            if (o.y0 < win_top) begin
                o.v0     = scale_mul(vs, longint'(win_top) - longint'(o.y0));
                o.y0     = win_top;
                o.flg[2] = 1'b1;
            end
            if (o.y1 > win_bottom) begin
                o.y1     = win_bottom;
                t        = longint'(o.v0)
                         + longint'(scale_mul(vs, longint'(o.y1) - longint'(o.y0)));
                o.v1     = t[31:0];
                o.flg[3] = 1'b1;
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report(string msg);
        if (errors < 100)
            $display("mismatch at word %0d: %s", n_words, msg);
        errors++;
    endtask

    task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_req(int px, int py, int sw, int sh, int tw, int th);
        t_blit_req r;
        r.px = 16'(px);
        r.py = 16'(py);
        r.sw = 16'(sw);
        r.sh = 16'(sh);
        r.tw = 15'(tw);
        r.th = 15'(th);
        req_q.push_back(r);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CLIP_LEFT:   win_left   = val;
            CFG_CLIP_TOP:    win_top    = val;
            CFG_CLIP_RIGHT:  win_right  = val;
            CFG_CLIP_BOTTOM: win_bottom = val;
            default: ;
        endcase
    endtask

    task automatic set_window(int l, int t, int r, int b);
        cfg_write(CFG_CLIP_LEFT, l);
        cfg_write(CFG_CLIP_TOP, t);
        cfg_write(CFG_CLIP_RIGHT, r);
        cfg_write(CFG_CLIP_BOTTOM, b);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic rand_window(bit frac);
        int xl;
        int yt;
        int w;
        int h;
        xl = int'($urandom_range(0, 3000)) - 1500;
        yt = int'($urandom_range(0, 3000)) - 1500;
        w  = int'($urandom_range(1, 800));
        h  = int'($urandom_range(1, 800));
        if (frac)
            set_window(xl * 65536 + int'($urandom_range(0, 65535)),
                       yt * 65536 + int'($urandom_range(0, 65535)),
                       (xl + w) * 65536 + int'($urandom_range(0, 65535)),
                       (yt + h) * 65536 + int'($urandom_range(0, 65535)));
        else
            set_window(xl * 65536, yt * 65536, (xl + w) * 65536, (yt + h) * 65536);
    endtask

    function automatic int clamp16(int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic logic [14:0] pick_tex();
        case ($urandom_range(0, 3))
            0:       return 15'($urandom_range(0, 64));
            1:       return 15'($urandom);
            2:       return $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
            default: return 15'($urandom_range(1, 1024));
        endcase
    endfunction

    // requests mostly straddle the current window, the rest is raw noise
    task automatic gen_phase(int n);
        int        lo_x;
        int        lo_y;
        int        wx;
        int        wy;
        int        k;
        t_blit_req r;
        lo_x = clamp16((int'(win_left) >>> 16) - 48);
        lo_y = clamp16((int'(win_top) >>> 16) - 48);
        wx   = clamp16((int'(win_right) >>> 16) + 48) - lo_x;
        wy   = clamp16((int'(win_bottom) >>> 16) + 48) - lo_y;
        if (wx < 1)
            wx = 64;
        if (wy < 1)
            wy = 64;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 2) begin
                r.px = 16'($urandom);
                r.py = 16'($urandom);
                r.sw = 16'($urandom);
                r.sh = 16'($urandom);
                r.tw = 15'($urandom);
                r.th = 15'($urandom);
            end else begin
                r.px = 16'(lo_x + int'($urandom_range(0, wx)));
                r.py = 16'(lo_y + int'($urandom_range(0, wy)));
                r.sw = 16'(int'($urandom_range(0, wx + 32)) - 16);
                r.sh = 16'(int'($urandom_range(0, wy + 32)) - 16);
                r.tw = pick_tex();
                r.th = pick_tex();
            end
            req_q.push_back(r);
        end
    endtask

    task automatic drain();
        while (req_q.size() != 0 || clip_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_fire) begin
            if (req_gap > 0) begin
                req_gap--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                cur_req       = req_q.pop_front();
                i_pos_x      <= cur_req.px;
                i_pos_y      <= cur_req.py;
                i_span_w     <= cur_req.sw;
                i_span_h     <= cur_req.sh;
                i_tex_width  <= cur_req.tw;
                i_tex_height <= cur_req.th;
                i_in_valid   <= 1'b1;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    req_gap = $urandom_range(1, 8);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else if (res_gap > 0) begin
            i_out_stall <= 1'b1;
            res_gap     <= res_gap - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_out_stall <= 1'b1;
            res_gap     <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // accept, predict and compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end else begin
            req_fire = i_rst_n && i_in_valid && !o_in_stall;
            if (req_fire)
                clip_q.push_back(clip_predict(cur_req));
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                mon_got = '{o_all_clipped, o_edge_flags, o_out_x0, o_out_y0, o_out_x1,
                            o_out_y1, o_out_u0, o_out_v0, o_out_u1, o_out_v1};
                if (clip_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    mon_want = clip_q.pop_front();
                    cmp_field("all_clipped", 32'(mon_got.rej), 32'(mon_want.rej));
                    cmp_field("edge_flags", 32'(mon_got.flg), 32'(mon_want.flg));
                    cmp_field("x0", mon_got.x0, mon_want.x0);
                    cmp_field("y0", mon_got.y0, mon_want.y0);
                    cmp_field("x1", mon_got.x1, mon_want.x1);
                    cmp_field("y1", mon_got.y1, mon_want.y1);
                    cmp_field("u0", mon_got.u0, mon_want.u0);
                    cmp_field("v0", mon_got.v0, mon_want.v0);
                    cmp_field("u1", mon_got.u1, mon_want.u1);
                    cmp_field("v1", mon_got.v1, mon_want.v1);
                end
                n_words++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty window after reset, everything rejected
        idle_pct = 20;
        add_req(0, 0, 0, 0, 0, 0);
        add_req(-32768, -32768, 32767, 32767, 32767, 32767);
        add_req(32767, 32767, -32768, -32768, 0, 32767);
        drain();

        // fixed window 10..200 x 20..150
        set_window(10 * 65536, 20 * 65536, 200 * 65536, 150 * 65536);
        add_req(50, 40, 100, 80, 64, 32);
        add_req(0, 0, 300, 200, 32767, 32767);
        add_req(-5, 40, 50, 50, 16, 16);
        add_req(150, 40, 100, 50, 16, 16);
        add_req(50, 5, 20, 60, 8, 100);
        add_req(50, 100, 20, 100, 8, 100);
        add_req(200, 40, 10, 10, 4, 4);
        add_req(0, 40, 10, 10, 4, 4);
        add_req(50, 150, 10, 10, 4, 4);
        add_req(50, 0, 10, 20, 4, 4);
        add_req(50, 40, 0, 10, 20, 20);
        add_req(50, 40, 10, 0, 20, 0);
        add_req(180, 40, -150, 10, 30, 30);
        add_req(50, 140, 10, -100, 30, 30);
        add_req(0, 0, 300, 200, 0, 0);
        add_req(-32768, 40, -32668, 50, 100, 100);
        add_req(-100, -100, 32767, 32767, 32767, 1);
        add_req(100, 40, 32767, 10, 5, 5);
        add_req(10, 20, 1, 1, 32767, 32767);
        drain();

        // full range window
        set_window(S32_MIN, S32_MIN, S32_MAX, S32_MAX);
        add_req(-32768, -32768, 0, 0, 1, 1);
        add_req(-32768, -32768, 1, 1, 32767, 32767);
        add_req(32767, 32767, 1, 1, 32767, 32767);
        gen_phase(150);
        drain();

        // random integer windows, one with a long result hold-off
        idle_pct = 0;
        rand_window(1'b0);
        gen_phase(140);
        drain();

        idle_pct = 35;
        rand_window(1'b0);
        gen_phase(140);
        drain();

        idle_pct = 5;
        rand_window(1'b0);
        hold_go = 1'b1;
        gen_phase(200);
        drain();

        // fractional window edges
        idle_pct = 15;
        rand_window(1'b1);
        gen_phase(140);
        drain();

        idle_pct = 40;
        rand_window(1'b1);
        gen_phase(140);
        drain();

        // inverted window, every request generated near it is rejected
        idle_pct = 15;
        set_window(300 * 65536, 300 * 65536, -300 * 65536, -300 * 65536);
        gen_phase(40);
        drain();

        idle_pct = 20;
        rand_window(1'b1);
        gen_phase(140);
        drain();

        // last part without idling
        idle_pct = 0;
        rand_window(1'b0);
        gen_phase(150);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && clip_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
